@@ src/mpi_pkg.sv @@
// ---------------------------------------------------------------------------
// mpi_pkg
// Shared constants and width helpers for the periodic minimum image block.
// ---------------------------------------------------------------------------
package mpi_pkg;

  // Cell and reciprocal coefficients are fixed 32-bit signed values.
  localparam int COEF_W     = 32;
  localparam int RECIP_FRAC = 30;
  localparam int SPLIT      = 16;
  localparam int LEN_W      = 31;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SKEWED_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X_PAIR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z_PAIR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_X_PAIR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_Z_PAIR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_Y        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LEN_Y    = 3'd6;

  // Width of the full dot product, kept wide enough to slice the integer part.
  function automatic int sum_width(input int cw, input int fw);
    int natural_w;
    int min_w;
    natural_w = cw + COEF_W + 3;
    min_w     = fw + RECIP_FRAC + 2;
    return (natural_w > min_w) ? natural_w : min_w;
  endfunction

  // Width of a rounded lattice index, one bit spare for the round-up.
  function automatic int idx_width(input int cw, input int fw);
    return sum_width(cw, fw) - (fw + RECIP_FRAC) + 1;
  endfunction

endpackage

@@ src/mpi_if.sv @@
// ---------------------------------------------------------------------------
// mpi_in_if / mpi_out_if
// Valid/ready channels carrying point pairs in and wrapped images out.
// ---------------------------------------------------------------------------
interface mpi_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ref_x;
  logic signed [COORD_WIDTH-1:0] ref_y;
  logic signed [COORD_WIDTH-1:0] ref_z;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;

  modport source (output valid, ref_x, ref_y, ref_z, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, ref_x, ref_y, ref_z, pos_x, pos_y, pos_z, output ready);
endinterface

interface mpi_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] image_x;
  logic signed [COORD_WIDTH-1:0] image_y;
  logic signed [COORD_WIDTH-1:0] image_z;

  modport source (output valid, image_x, image_y, image_z, input ready);
  modport sink   (input valid, image_x, image_y, image_z, output ready);
endinterface

@@ src/periodic_minimum_image_top.sv @@
// ---------------------------------------------------------------------------
// periodic_minimum_image_top
// Pipeline: a request passes the difference register, three lattice stages,
// back-mapping and the output register.
// Throughput: one request per cycle; the whole pipeline holds while a
// result waits on the output, and bubbles pass through as invalid slots.
// Reset clears all valid bits and every configuration register to zero.
// ---------------------------------------------------------------------------
module periodic_minimum_image_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mpi_in_if.sink                        in_ch,
  mpi_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpi_pkg::CFG_W-1:0]     cfg_data
);
  import mpi_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int NW = idx_width(COORD_WIDTH, FRAC_BITS);
  localparam int LAT_STAGES = 4;

  // Configuration registers.
  logic              skewed_r;
  logic [CFG_W-1:0]  axis_x_r, axis_z_r, recip_x_r, recip_z_r;
  logic [LEN_W-1:0]  len_y_r, inv_len_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skewed_r    <= 1'b0;
      axis_x_r    <= '0;
      axis_z_r    <= '0;
      recip_x_r   <= '0;
      recip_z_r   <= '0;
      len_y_r     <= '0;
      inv_len_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SKEWED_MODE:  skewed_r    <= cfg_data[0];
        REG_AXIS_X_PAIR:  axis_x_r    <= cfg_data;
        REG_AXIS_Z_PAIR:  axis_z_r    <= cfg_data;
        REG_RECIP_X_PAIR: recip_x_r   <= cfg_data;
        REG_RECIP_Z_PAIR: recip_z_r   <= cfg_data;
        REG_LEN_Y:        len_y_r     <= cfg_data[LEN_W-1:0];
        REG_INV_LEN_Y:    inv_len_y_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // In rectangular mode the x-z cross terms drop out.
  logic signed [COEF_W-1:0] bx_x, bx_z, bz_x, bz_z, inv_y;
  logic signed [COEF_W-1:0] ax_x, ax_z, az_x, az_z, len_y;

  always_comb begin
    bx_x  = recip_x_r[COEF_W-1:0];
    bx_z  = skewed_r ? recip_x_r[2*COEF_W-1:COEF_W] : '0;
    bz_x  = skewed_r ? recip_z_r[COEF_W-1:0] : '0;
    bz_z  = recip_z_r[2*COEF_W-1:COEF_W];
    inv_y = $signed({1'b0, inv_len_y_r});
    ax_x  = axis_x_r[COEF_W-1:0];
    ax_z  = skewed_r ? axis_x_r[2*COEF_W-1:COEF_W] : '0;
    az_x  = skewed_r ? axis_z_r[COEF_W-1:0] : '0;
    az_z  = axis_z_r[2*COEF_W-1:COEF_W];
    len_y = $signed({1'b0, len_y_r});
  end

  // Every stage moves together; the pipeline holds only when the output
  // register is full and not being taken.
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: difference vector and position.
  logic signed [CW:0]   dx_r, dy_r, dz_r;
  logic [LAT_STAGES-1:0] vld_r;
  logic [3*CW-1:0]      pos_r [LAT_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r     <= (CW+1)'(in_ch.pos_x) - (CW+1)'(in_ch.ref_x);
      dy_r     <= (CW+1)'(in_ch.pos_y) - (CW+1)'(in_ch.ref_y);
      dz_r     <= (CW+1)'(in_ch.pos_z) - (CW+1)'(in_ch.ref_z);
      pos_r[0] <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
      for (int i = 1; i < LAT_STAGES; i++) begin
        pos_r[i] <= pos_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT_STAGES-2:0], in_ch.valid};
    end
  end

  // Stages 2 to 4: lattice indexes.
  logic signed [NW-1:0] n0, n1, n2;
  logic signed [CW:0]   zero_d;
  assign zero_d = '0;

  mpi_lattice #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lat_x (
    .clk(clk), .en(en), .coef_a(bx_x), .coef_b(bx_z), .d0(dx_r), .d2(dz_r), .idx(n0)
  );

  mpi_lattice #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lat_z (
    .clk(clk), .en(en), .coef_a(bz_x), .coef_b(bz_z), .d0(dx_r), .d2(dz_r), .idx(n2)
  );

  mpi_lattice #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lat_y (
    .clk(clk), .en(en), .coef_a(inv_y), .coef_b('0), .d0(dy_r), .d2(zero_d), .idx(n1)
  );

  // Stages 5 and 6: back-mapping and output register.
  logic signed [CW-1:0] px4, py4, pz4;
  assign px4 = pos_r[LAT_STAGES-1][CW-1:0];
  assign py4 = pos_r[LAT_STAGES-1][2*CW-1:CW];
  assign pz4 = pos_r[LAT_STAGES-1][3*CW-1:2*CW];

  mpi_image #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_image (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld_r[LAT_STAGES-1]),
    .n0(n0), .n1(n1), .n2(n2), .px(px4), .py(py4), .pz(pz4),
    .ax_x(ax_x), .az_x(az_x), .ax_z(ax_z), .az_z(az_z), .len_y(len_y),
    .out_vld(out_ch.valid), .image_x(out_ch.image_x), .image_y(out_ch.image_y),
    .image_z(out_ch.image_z)
  );

endmodule

@@ src/mpi_lattice.sv @@
// ---------------------------------------------------------------------------
// mpi_lattice
// Three-stage lattice index unit: split products, full sum, then rounding to
// the nearest integer with ties to even.
// ---------------------------------------------------------------------------
module mpi_lattice #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [mpi_pkg::COEF_W-1:0]   coef_a,
  input  logic signed [mpi_pkg::COEF_W-1:0]   coef_b,
  input  logic signed [COORD_WIDTH:0]         d0,
  input  logic signed [COORD_WIDTH:0]         d2,
  output logic signed [mpi_pkg::idx_width(COORD_WIDTH, FRAC_BITS)-1:0] idx
);
  import mpi_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int HW  = DW - SPLIT;
  localparam int PLW = COEF_W + SPLIT + 1;
  localparam int PHW = COEF_W + HW;
  localparam int SW  = sum_width(COORD_WIDTH, FRAC_BITS);
  localparam int K   = FRAC_BITS + RECIP_FRAC;
  localparam int QW  = SW - K;
  localparam int NW  = idx_width(COORD_WIDTH, FRAC_BITS);
  localparam logic [K-1:0] HALF = K'(1) << (K - 1);

  // Stage 1: the coordinate is split into an unsigned low part and a signed
  // high part so each product stays within a 32x17 multiplier.
  logic signed [PLW-1:0] pl0_r, pl2_r, pl0_nxt, pl2_nxt;
  logic signed [PHW-1:0] ph0_r, ph2_r, ph0_nxt, ph2_nxt;

  always_comb begin
    pl0_nxt = PLW'(coef_a) * PLW'($signed({1'b0, d0[SPLIT-1:0]}));
    pl2_nxt = PLW'(coef_b) * PLW'($signed({1'b0, d2[SPLIT-1:0]}));
    ph0_nxt = PHW'(coef_a) * PHW'($signed(d0[DW-1:SPLIT]));
    ph2_nxt = PHW'(coef_b) * PHW'($signed(d2[DW-1:SPLIT]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl0_r <= pl0_nxt;
      pl2_r <= pl2_nxt;
      ph0_r <= ph0_nxt;
      ph2_r <= ph2_nxt;
    end
  end

  // Stage 2: recombine into the exact dot product.
  logic signed [SW-1:0] sum_r, sum_nxt;

  always_comb begin
    sum_nxt = ((SW'(ph0_r) + SW'(ph2_r)) <<< SPLIT) + SW'(pl0_r) + SW'(pl2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  // Stage 3: floor to the integer part, then round up above half or on an
  // exact half when the floor is odd.
  logic signed [QW-1:0] quo;
  logic [K-1:0]         rem;
  logic                 round_up;
  logic signed [NW-1:0] idx_r, idx_nxt;

  always_comb begin
    quo      = sum_r[SW-1:K];
    rem      = sum_r[K-1:0];
    round_up = (rem > HALF) || ((rem == HALF) && quo[0]);
    idx_nxt  = NW'(quo) + NW'($signed({1'b0, round_up}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r <= idx_nxt;
    end
  end

  assign idx = idx_r;

endmodule

@@ src/mpi_image.sv @@
// ---------------------------------------------------------------------------
// mpi_image
// Maps lattice indexes back through the cell axes, subtracts the shift from
// the position and saturates into the output register.
// ---------------------------------------------------------------------------
module mpi_image #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [mpi_pkg::idx_width(COORD_WIDTH, FRAC_BITS)-1:0] n0,
  input  logic signed [mpi_pkg::idx_width(COORD_WIDTH, FRAC_BITS)-1:0] n1,
  input  logic signed [mpi_pkg::idx_width(COORD_WIDTH, FRAC_BITS)-1:0] n2,
  input  logic signed [COORD_WIDTH-1:0]       px,
  input  logic signed [COORD_WIDTH-1:0]       py,
  input  logic signed [COORD_WIDTH-1:0]       pz,
  input  logic signed [mpi_pkg::COEF_W-1:0]   ax_x,
  input  logic signed [mpi_pkg::COEF_W-1:0]   az_x,
  input  logic signed [mpi_pkg::COEF_W-1:0]   ax_z,
  input  logic signed [mpi_pkg::COEF_W-1:0]   az_z,
  input  logic signed [mpi_pkg::COEF_W-1:0]   len_y,
  output logic                                out_vld,
  output logic signed [COORD_WIDTH-1:0]       image_x,
  output logic signed [COORD_WIDTH-1:0]       image_y,
  output logic signed [COORD_WIDTH-1:0]       image_z
);
  import mpi_pkg::*;

  localparam int NW  = idx_width(COORD_WIDTH, FRAC_BITS);
  localparam int PW  = NW + COEF_W;
  localparam int CSW = PW + 1;
  localparam int EW  = ((COORD_WIDTH > CSW) ? COORD_WIDTH : CSW) + 2;
  localparam logic signed [EW-1:0] SAT_HI = EW'((65'(1) << (COORD_WIDTH - 1)) - 65'(1));
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  function automatic logic signed [COORD_WIDTH-1:0] saturate(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[COORD_WIDTH-1:0];
  endfunction

  // Stage 1: one product per lattice term.
  logic signed [PW-1:0] pxx_r, pxz_r, pzx_r, pzz_r, py_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_pos_r, pz_r;
  logic vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r    <= PW'(n0) * PW'(ax_x);
      pxz_r    <= PW'(n2) * PW'(az_x);
      pzx_r    <= PW'(n0) * PW'(ax_z);
      pzz_r    <= PW'(n2) * PW'(az_z);
      py_r     <= PW'(n1) * PW'(len_y);
      px_r     <= px;
      py_pos_r <= py;
      pz_r     <= pz;
    end
  end

  // Stage 2: subtract the lattice shift and clamp.
  logic signed [EW-1:0] wx, wy, wz;
  logic signed [COORD_WIDTH-1:0] img_x_r, img_y_r, img_z_r;
  logic signed [COORD_WIDTH-1:0] img_x_nxt, img_y_nxt, img_z_nxt;
  logic out_vld_r;

  always_comb begin
    wx = EW'(px_r) - EW'(pxx_r) - EW'(pxz_r);
    wy = EW'(py_pos_r) - EW'(py_r);
    wz = EW'(pz_r) - EW'(pzx_r) - EW'(pzz_r);
    img_x_nxt = saturate(wx);
    img_y_nxt = saturate(wy);
    img_z_nxt = saturate(wz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      img_x_r <= img_x_nxt;
      img_y_r <= img_y_nxt;
      img_z_r <= img_z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= in_vld;
      out_vld_r <= vld_r;
    end
  end

  assign out_vld = out_vld_r;
  assign image_x = img_x_r;
  assign image_y = img_y_r;
  assign image_z = img_z_r;

endmodule
